/* sv/volume_gradient_encoder_unit_assert.svh */
// Assertion macros shared by the volume gradient encoder RTL
`ifndef VOLUME_GRADIENT_ENCODER_UNIT_ASSERT_SVH
`define VOLUME_GRADIENT_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define VGE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define VGE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/vge_pkg.sv */
// Types, constants and helper functions of the volume gradient encoder
`default_nettype none
package vge_pkg;

  localparam int POS_W  = 8;
  localparam int SIZE_W = 9;
  localparam int VAL_W  = 8;
  localparam int MAG_W  = 8;
  localparam int SQ_W   = 16;
  localparam int SW     = 18;  // sum of three squares
  localparam int RW     = 30;  // scaled square of one difference
  localparam int PW     = 30;  // k*k*S, never above R
  localparam int QW     = 25;  // k*S
  localparam int KW     = 7;
  localparam int TW     = 33;  // trial sum in one search step
  localparam int NSRCH  = 7;   // one search step per bit of k
  localparam int MAX_Z  = 256;

  localparam logic [13:0] ENC_SCALE = 14'd16129;  // 127 squared
  localparam logic [7:0]  ENC_MID   = 8'd127;
  localparam logic [7:0]  ENC_MAX   = 8'd254;
  localparam logic [7:0]  ENC_MIN   = 8'd0;
  localparam logic [8:0]  SIZE_RST  = 9'd256;

  typedef enum logic [1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BND_NONE,
    BND_X_LO,
    BND_X_HI,
    BND_Y_LO,
    BND_Y_HI,
    BND_Z_LO,
    BND_Z_HI
  } bnd_e;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } pos_t;

  // Per-request control that rides along with the gradient data
  typedef struct packed {
    pos_t             pos;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] alpha;
    logic             has_prev;
    logic             has_own;
    bnd_e             bnd_prev;
    bnd_e             bnd_own;
  } meta_t;

  // Search state for the three components: P = k*k*S, Q = k*S
  typedef struct packed {
    logic [SW-1:0]          s;
    logic [2:0][RW-1:0]     r;
    logic [2:0]             neg;
    logic [2:0][PW-1:0]     p;
    logic [2:0][QW-1:0]     q;
    logic [2:0][KW-1:0]     k;
  } grad_t;

  // Index 0 red, 1 green, 2 blue
  typedef logic [2:0][7:0] rgb_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                 input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] e;
    e = (r == '0) ? SIZE_W'(1) : r;
    if (e > lim) e = lim;
    return e;
  endfunction

  function automatic bnd_e bnd_code(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                    input logic [POS_W-1:0] z, input logic [SIZE_W-1:0] sx,
                                    input logic [SIZE_W-1:0] sy,
                                    input logic [SIZE_W-1:0] sz);
    bnd_e b;
    b = BND_NONE;
    if (x == '0) b = BND_X_LO;
    else if ({1'b0, x} == sx - SIZE_W'(1)) b = BND_X_HI;
    else if (y == '0) b = BND_Y_LO;
    else if ({1'b0, y} == sy - SIZE_W'(1)) b = BND_Y_HI;
    else if (z == '0) b = BND_Z_LO;
    else if ({1'b0, z} == sz - SIZE_W'(1)) b = BND_Z_HI;
    return b;
  endfunction

  function automatic rgb_t bnd_rgb(input bnd_e b);
    rgb_t c;
    c = {ENC_MID, ENC_MID, ENC_MID};
    case (b)
      BND_X_LO: c[0] = ENC_MIN;
      BND_X_HI: c[0] = ENC_MAX;
      BND_Y_LO: c[1] = ENC_MIN;
      BND_Y_HI: c[1] = ENC_MAX;
      BND_Z_LO: c[2] = ENC_MIN;
      BND_Z_HI: c[2] = ENC_MAX;
      default: ;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/vge_ram.sv */
// Generic RAM: one write port, two registered read ports, read-first
`default_nettype none
module vge_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr0_i,
  input  wire logic [AW-1:0] raddr1_i,
  output logic      [W-1:0]  rdata0_o,
  output logic      [W-1:0]  rdata1_o
);

  logic [W-1:0] mem [DEPTH];

  // Read old contents, then write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

/* sv/vge_pos.sv */
// Raster position counter with restart on out-of-range position
`default_nettype none
module vge_pos import vge_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic [SIZE_W-1:0] sx_i,
  input  wire logic [SIZE_W-1:0] sy_i,
  input  wire logic [SIZE_W-1:0] sz_i,
  output pos_t                   pos_o
);

  pos_t              cur_q, cur_d;
  logic              oor;
  logic [SIZE_W-1:0] nx, ny, nz;

  // Restart at the origin when a size change left us outside the volume
  always_comb begin
    oor   = ({1'b0, cur_q.x} >= sx_i) || ({1'b0, cur_q.y} >= sy_i) ||
            ({1'b0, cur_q.z} >= sz_i);
    pos_o = oor ? '0 : cur_q;
    nx    = {1'b0, pos_o.x} + SIZE_W'(1);
    ny    = {1'b0, pos_o.y} + SIZE_W'(1);
    nz    = {1'b0, pos_o.z} + SIZE_W'(1);
    cur_d = pos_o;
    if (nx >= sx_i) begin
      cur_d.x = '0;
      if (ny >= sy_i) begin
        cur_d.y = '0;
        cur_d.z = (nz >= sz_i) ? '0 : nz[POS_W-1:0];
      end else begin
        cur_d.y = ny[POS_W-1:0];
      end
    end else begin
      cur_d.x = nx[POS_W-1:0];
    end
  end

  // Advance on every accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else if (adv_i) begin
      cur_q <= cur_d;
    end
  end

endmodule
`default_nettype wire

/* sv/vge_srch.sv */
// One bit of the square-root search for all three gradient components
`default_nettype none
module vge_srch import vge_pkg::*; #(
  parameter int BIT = 0
) (
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire grad_t g_i,
  output grad_t      g_o
);

  grad_t         g_d;
  logic [TW-1:0] t [3];

  // Try k + 2^BIT: keep it while (k + 2^BIT)^2 * S stays within R
  always_comb begin
    g_d = g_i;
    for (int i = 0; i < 3; i++) begin
      t[i] = TW'(g_i.p[i]) + (TW'(g_i.q[i]) << (BIT + 1)) + (TW'(g_i.s) << (2 * BIT));
      if (t[i] <= TW'(g_i.r[i])) begin
        g_d.p[i]      = t[i][PW-1:0];
        g_d.q[i]      = g_i.q[i] + (QW'(g_i.s) << BIT);
        g_d.k[i][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_o <= g_d;
    end
  end

endmodule
`default_nettype wire

/* sv/volume_gradient_encoder_unit.sv */
// Top level of the volume gradient encoder: plane store, pipeline and output stage
//
// Voxels arrive on the input channel (in_valid_i/in_ready_o, voxel_value_i) in
// raster order, x fastest. Each request writes the plane store and, past the
// first plane, releases the RGBA result of the voxel at the same x,y one plane
// back; on the last plane the voxel's own result follows right after it. Results
// leave on the output channel (out_valid_o/out_ready_i) with their coordinates;
// last_of_run_o marks the final result of a request. Sizes are set through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only while the block
// is idle, and the block itself does not enforce this. Throughput: one request per
// cycle while the output does not stall, set by the single write port of the
// plane store; a request with two results holds the output stage for both.
// The gradient norm is resolved by a 7-stage bit search, one bit per stage.
// Reset clears the position to the origin, the sizes to 256 and all valid bits;
// the plane store is not cleared and holds data only once a plane is written.
// When the receiver stalls, the pipeline keeps filling its empty stages and drops
// in_ready_o only once every stage holds a request.
`default_nettype none
`include "volume_gradient_encoder_unit_assert.svh"
module volume_gradient_encoder_unit import vge_pkg::*; #(
  parameter int MAX_X = 256,
  parameter int MAX_Y = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [VAL_W-1:0]  voxel_value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [POS_W-1:0]       pos_x_o,
  output logic [POS_W-1:0]       pos_y_o,
  output logic [POS_W-1:0]       pos_z_o,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o,
  output logic [7:0]             alpha_o,
  output logic                   last_of_run_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [SIZE_W-1:0] cfg_data_i
);

  localparam int LIM_X  = (MAX_X < 256) ? MAX_X : 256;
  localparam int LIM_Y  = (MAX_Y < 256) ? MAX_Y : 256;
  localparam int LIM_Z  = (MAX_Z < 256) ? MAX_Z : 256;
  localparam logic [SIZE_W-1:0] LIM_X9 = SIZE_W'(LIM_X);
  localparam logic [SIZE_W-1:0] LIM_Y9 = SIZE_W'(LIM_Y);
  localparam logic [SIZE_W-1:0] LIM_Z9 = SIZE_W'(LIM_Z);
  localparam int XAW    = (LIM_X > 1) ? $clog2(LIM_X) : 1;
  localparam int YAW    = (LIM_Y > 1) ? $clog2(LIM_Y) : 1;
  localparam int AW     = 1 + XAW + YAW;
  localparam int DEPTH  = 2 ** AW;
  localparam int ST_LAST = 4 + NSRCH;

  // Configuration
  logic [SIZE_W-1:0] sx_q, sy_q, sz_q;
  logic [SIZE_W-1:0] sx, sy, sz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= SIZE_RST;
      sy_q <= SIZE_RST;
      sz_q <= SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SIZE_X: sx_q <= cfg_data_i;
        CFG_SIZE_Y: sy_q <= cfg_data_i;
        CFG_SIZE_Z: sz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sx = eff_size(sx_q, LIM_X9);
  assign sy = eff_size(sy_q, LIM_Y9);
  assign sz = eff_size(sz_q, LIM_Z9);

  // Pipeline control: a stage loads when empty or when the next one moves
  logic [ST_LAST+1:1] en;
  logic [ST_LAST:1]   v_q;
  logic               ov_q, phase_q, out_done, accept;

  always_comb begin
    en[ST_LAST+1] = !ov_q || out_done;
    for (int k = ST_LAST; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[1];
  assign accept     = in_valid_i && en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= ST_LAST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Position and request control
  pos_t  pos;
  meta_t meta0;

  vge_pos u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (accept),
    .sx_i   (sx),
    .sy_i   (sy),
    .sz_i   (sz),
    .pos_o  (pos)
  );

  always_comb begin
    meta0          = '0;
    meta0.pos      = pos;
    meta0.v        = voxel_value_i;
    meta0.has_prev = (pos.z != '0);
    meta0.has_own  = ({1'b0, pos.z} == sz - SIZE_W'(1));
    meta0.bnd_prev = bnd_code(pos.x, pos.y, pos.z - POS_W'(1), sx, sy, sz);
    meta0.bnd_own  = bnd_code(pos.x, pos.y, pos.z, sx, sy, sz);
  end

  // Plane store addresses: previous plane slot and the current plane slot
  logic [POS_W-1:0] xm, xp, ym, yp;
  logic [AW-1:0]    a_w, a_c, a_xm, a_xp, a_ym, a_yp;
  logic             slot_p;

  always_comb begin
    slot_p = ~pos.z[0];
    xm     = pos.x - POS_W'(1);
    xp     = pos.x + POS_W'(1);
    ym     = pos.y - POS_W'(1);
    yp     = pos.y + POS_W'(1);
    a_w    = {pos.z[0], pos.y[YAW-1:0], pos.x[XAW-1:0]};
    a_c    = {slot_p, pos.y[YAW-1:0], pos.x[XAW-1:0]};
    a_xm   = {slot_p, pos.y[YAW-1:0], xm[XAW-1:0]};
    a_xp   = {slot_p, pos.y[YAW-1:0], xp[XAW-1:0]};
    a_ym   = {slot_p, ym[YAW-1:0], pos.x[XAW-1:0]};
    a_yp   = {slot_p, yp[YAW-1:0], pos.x[XAW-1:0]};
  end

  // Three copies of the store give six reads per cycle
  logic [VAL_W-1:0] rd_c, rd_z, rd_xm, rd_xp, rd_ym, rd_yp;

  vge_ram #(.W(VAL_W), .DEPTH(DEPTH)) u_ram_c (
    .clk_i    (clk_i),
    .we_i     (accept),
    .waddr_i  (a_w),
    .wdata_i  (voxel_value_i),
    .re_i     (en[1]),
    .raddr0_i (a_c),
    .raddr1_i (a_w),
    .rdata0_o (rd_c),
    .rdata1_o (rd_z)
  );

  vge_ram #(.W(VAL_W), .DEPTH(DEPTH)) u_ram_x (
    .clk_i    (clk_i),
    .we_i     (accept),
    .waddr_i  (a_w),
    .wdata_i  (voxel_value_i),
    .re_i     (en[1]),
    .raddr0_i (a_xm),
    .raddr1_i (a_xp),
    .rdata0_o (rd_xm),
    .rdata1_o (rd_xp)
  );

  vge_ram #(.W(VAL_W), .DEPTH(DEPTH)) u_ram_y (
    .clk_i    (clk_i),
    .we_i     (accept),
    .waddr_i  (a_w),
    .wdata_i  (voxel_value_i),
    .re_i     (en[1]),
    .raddr0_i (a_ym),
    .raddr1_i (a_yp),
    .rdata0_o (rd_ym),
    .rdata1_o (rd_yp)
  );

  meta_t                meta_q [1:ST_LAST];
  logic [2:0][MAG_W-1:0] mag_q;
  logic [2:0]           neg2_q, neg3_q;
  logic [2:0][SQ_W-1:0] sq_q;
  grad_t                g4_q;
  grad_t                g_s [4:ST_LAST];
  meta_t                m2_d;
  grad_t                g4_d;

  // Central differences, split into magnitude and sign
  logic [2:0][SIZE_W-1:0] d;
  logic [2:0][SIZE_W-1:0] dn;

  always_comb begin
    d[0] = {1'b0, rd_xm} - {1'b0, rd_xp};
    d[1] = {1'b0, rd_ym} - {1'b0, rd_yp};
    d[2] = {1'b0, rd_z} - {1'b0, meta_q[1].v};
    for (int i = 0; i < 3; i++) begin
      dn[i] = ~d[i] + SIZE_W'(1);
    end
  end

  // Attach alpha; form the sum of squares and the scaled squares, k = 0
  always_comb begin
    m2_d       = meta_q[1];
    m2_d.alpha = rd_c;
    g4_d       = '0;
    g4_d.s     = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    g4_d.neg   = neg3_q;
    for (int i = 0; i < 3; i++) begin
      g4_d.r[i] = RW'(ENC_SCALE) * RW'(sq_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) meta_q[1] <= meta0;
    if (en[2]) begin
      meta_q[2] <= m2_d;
      for (int i = 0; i < 3; i++) begin
        neg2_q[i] <= d[i][SIZE_W-1];
        mag_q[i]  <= d[i][SIZE_W-1] ? dn[i][MAG_W-1:0] : d[i][MAG_W-1:0];
      end
    end
    // Square each magnitude
    if (en[3]) begin
      neg3_q <= neg2_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= mag_q[i] * mag_q[i];
      end
    end
    // Sum of squares and the scaled squares, search starts at k = 0
    if (en[4]) begin
      g4_q <= g4_d;
    end
    for (int k = 3; k <= ST_LAST; k++) begin
      if (en[k]) meta_q[k] <= meta_q[k-1];
    end
  end

  assign g_s[4] = g4_q;

  // Bit search for k = floor(127*|d|/sqrt(S)), most significant bit first
  for (genvar j = 0; j < NSRCH; j++) begin : g_srch
    vge_srch #(.BIT(NSRCH - 1 - j)) u_srch (
      .clk_i (clk_i),
      .en_i  (en[5+j]),
      .g_i   (g_s[4+j]),
      .g_o   (g_s[5+j])
    );
  end

  // Encode the released result; negative components round away from zero
  rgb_t       rgb_prev;
  logic [7:0] kk [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kk[i] = {1'b0, g_s[ST_LAST].k[i]} +
              8'(g_s[ST_LAST].p[i] != g_s[ST_LAST].r[i]);
      rgb_prev[i] = g_s[ST_LAST].neg[i] ? (ENC_MID - kk[i])
                                        : (ENC_MID + {1'b0, g_s[ST_LAST].k[i]});
    end
    if (meta_q[ST_LAST].bnd_prev != BND_NONE) begin
      rgb_prev = bnd_rgb(meta_q[ST_LAST].bnd_prev);
    end else if (g_s[ST_LAST].s == '0) begin
      rgb_prev = {ENC_MID, ENC_MID, ENC_MID};
    end
  end

  // Output stage: holds one request with up to two results
  meta_t om_q;
  rgb_t  orgb_q;
  logic  emit_prev;
  rgb_t  rgb_out;

  always_ff @(posedge clk_i) begin
    if (en[ST_LAST+1]) begin
      om_q   <= meta_q[ST_LAST];
      orgb_q <= rgb_prev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      phase_q <= 1'b0;
    end else if (en[ST_LAST+1]) begin
      ov_q    <= v_q[ST_LAST] && (meta_q[ST_LAST].has_prev || meta_q[ST_LAST].has_own);
      phase_q <= 1'b0;
    end else if (ov_q && out_ready_i) begin
      phase_q <= 1'b1;
    end
  end

  always_comb begin
    emit_prev     = om_q.has_prev && !phase_q;
    rgb_out       = emit_prev ? orgb_q : bnd_rgb(om_q.bnd_own);
    out_valid_o   = ov_q;
    pos_x_o       = om_q.pos.x;
    pos_y_o       = om_q.pos.y;
    pos_z_o       = emit_prev ? (om_q.pos.z - POS_W'(1)) : om_q.pos.z;
    red_o         = rgb_out[0];
    green_o       = rgb_out[1];
    blue_o        = rgb_out[2];
    alpha_o       = emit_prev ? om_q.alpha : om_q.v;
    last_of_run_o = !(emit_prev && om_q.has_own);
    out_done      = ov_q && out_ready_i && last_of_run_o;
  end

  `VGE_ASSERT_IMP(a_stall_full, !in_ready_o, (&v_q) && ov_q, "input held off with room in the pipeline")
  `VGE_ASSERT_IMP(a_phase_own, phase_q, ov_q && om_q.has_own && om_q.has_prev, "second result without a pair")
  `VGE_ASSERT_NXT(a_pair_follows, out_valid_o && out_ready_i && !last_of_run_o, out_valid_o && last_of_run_o, "own result did not follow")

endmodule
`default_nettype wire

/* tb/vge_checker.sv */
// Result checker for the volume gradient encoder: predicts each RGBA result and compares it
`timescale 1ns / 100ps
module vge_checker import vge_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [VAL_W-1:0]  voxel_value_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [POS_W-1:0]  pos_x_i,
  input  logic [POS_W-1:0]  pos_y_i,
  input  logic [POS_W-1:0]  pos_z_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic [7:0]        alpha_i,
  input  logic              last_of_run_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  output int                mismatch_cnt_o,
  output int                pending_cnt_o,
  output int                result_cnt_o
);

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } rgba_t;

  rgba_t             rgba_q[$];
  logic [7:0]        plane_mem [2][256][256];
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  int                cur_x, cur_y, cur_z;
  int                mismatches, pending, results;

  assign mismatch_cnt_o = mismatches;
  assign pending_cnt_o  = pending;
  assign result_cnt_o   = results;

  // Clamp a size register to 1..256
  function automatic int dim_of(input logic [SIZE_W-1:0] r);
    if (r == '0) return 1;
    if (r > 9'd256) return 256;
    return int'(r);
  endfunction

  // Exact floor(127 + 127*d/sqrt(s)) by search on squares
  function automatic logic [7:0] encode_axis(input longint d, input longint s);
    longint ad, rhs, k;
    ad  = (d < 0) ? -d : d;
    rhs = 16129 * ad * ad;
    k   = 0;
    if (d >= 0) begin
      while (k < 127 && (k + 1) * (k + 1) * s <= rhs) k++;
      return 8'(127 + k);
    end
    while (k < 127 && k * k * s < rhs) k++;
    return 8'(127 - k);
  endfunction

  function automatic rgba_t shade(input int x, input int y, input int z, input int sx,
                                 input int sy, input int sz, input logic [7:0] a,
                                 input int dx, input int dy, input int dz);
    rgba_t  o;
    longint s;
    o = '{x: 8'(x), y: 8'(y), z: 8'(z), r: ENC_MID, g: ENC_MID, b: ENC_MID, a: a,
          last: 1'b0};
    s = longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz;
    if (x == 0) o.r = ENC_MIN;
    else if (x == sx - 1) o.r = ENC_MAX;
    else if (y == 0) o.g = ENC_MIN;
    else if (y == sy - 1) o.g = ENC_MAX;
    else if (z == 0) o.b = ENC_MIN;
    else if (z == sz - 1) o.b = ENC_MAX;
    else if (s != 0) begin
      o.r = encode_axis(dx, s);
      o.g = encode_axis(dy, s);
      o.b = encode_axis(dz, s);
    end
    return o;
  endfunction

  // Release the previous-plane result and, on the last plane, the voxel's own
  task automatic predict_voxel(input logic [7:0] v);
    int    sx, sy, sz, x, y, z, pz, dx, dy, dz;
    rgba_t prev, own;
    sx = dim_of(size_x_q);
    sy = dim_of(size_y_q);
    sz = dim_of(size_z_q);
    if (cur_x >= sx || cur_y >= sy || cur_z >= sz) begin
      cur_x = 0;
      cur_y = 0;
      cur_z = 0;
    end
    x = cur_x;
    y = cur_y;
    z = cur_z;
    if (z > 0) begin
      pz = z - 1;
      dx = 0;
      dy = 0;
      dz = 0;
      if (x > 0 && x + 1 < sx && y > 0 && y + 1 < sy && pz > 0) begin
        dx = int'(plane_mem[pz & 1][y][x - 1]) - int'(plane_mem[pz & 1][y][x + 1]);
        dy = int'(plane_mem[pz & 1][y - 1][x]) - int'(plane_mem[pz & 1][y + 1][x]);
        dz = int'(plane_mem[z & 1][y][x]) - int'(v);
      end
      prev = shade(x, y, pz, sx, sy, sz, plane_mem[pz & 1][y][x], dx, dy, dz);
      prev.last = (z != sz - 1);
      rgba_q = {rgba_q, prev};
      pending++;
    end
    if (z == sz - 1) begin
      own = shade(x, y, z, sx, sy, sz, v, 0, 0, 0);
      own.last = 1'b1;
      rgba_q = {rgba_q, own};
      pending++;
    end
    plane_mem[z & 1][y][x] = v;
    // Advance the raster position, wrapping at the end of the volume
    cur_x++;
    if (cur_x >= sx) begin
      cur_x = 0;
      cur_y++;
      if (cur_y >= sy) begin
        cur_y = 0;
        cur_z++;
        if (cur_z >= sz) cur_z = 0;
      end
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("ERROR result %0d field %s: got %0d, expected %0d", results, field, got, want);
    mismatches++;
  endtask

  // Track config, predict on input requests, compare on output requests
  always @(posedge clk_i or negedge rst_ni) begin
    rgba_t want;
    if (!rst_ni) begin
      rgba_q.delete();
      size_x_q   = SIZE_RST;
      size_y_q   = SIZE_RST;
      size_z_q   = SIZE_RST;
      cur_x      = 0;
      cur_y      = 0;
      cur_z      = 0;
      mismatches = 0;
      pending    = 0;
      results    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SIZE_X: size_x_q = cfg_data_i;
          CFG_SIZE_Y: size_y_q = cfg_data_i;
          CFG_SIZE_Z: size_z_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_voxel(voxel_value_i);
      if (out_valid_i && out_ready_i) begin
        if (rgba_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = rgba_q.pop_front();
          pending--;
          if (pos_x_i !== want.x) report_mismatch("pos_x", pos_x_i, want.x);
          if (pos_y_i !== want.y) report_mismatch("pos_y", pos_y_i, want.y);
          if (pos_z_i !== want.z) report_mismatch("pos_z", pos_z_i, want.z);
          if (red_i !== want.r) report_mismatch("red", red_i, want.r);
          if (green_i !== want.g) report_mismatch("green", green_i, want.g);
          if (blue_i !== want.b) report_mismatch("blue", blue_i, want.b);
          if (alpha_i !== want.a) report_mismatch("alpha", alpha_i, want.a);
          if (last_of_run_i !== want.last)
            report_mismatch("last_of_run", last_of_run_i, want.last);
        end
        results++;
      end
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top for the volume gradient encoder: stimulus, flow control and verdict
`timescale 1ns / 100ps
module tb;
  import vge_pkg::*;

  localparam logic [1:0] CFG_IDX_SPARE = 2'd3;
  localparam int         CYCLE_LIMIT   = 500000;
  localparam int         TARGET_ITEMS  = 1500;
  localparam int         DRAIN_CYCLES  = 20;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [VAL_W-1:0]  voxel_value_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [POS_W-1:0]  pos_x_o, pos_y_o, pos_z_o;
  logic [7:0]        red_o, green_o, blue_o, alpha_o;
  logic              last_of_run_o;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [SIZE_W-1:0] cfg_data_i;

  int mismatch_cnt, pending_cnt, result_cnt;
  int cycle_cnt;
  int sent_cnt;
  int volume_cnt;
  int send_idle_pct, recv_idle_pct;
  int stall_left;
  bit stall_req;

  volume_gradient_encoder_unit u_dut (.*);

  vge_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .voxel_value_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .pos_z_i(pos_z_o),
    .red_i(red_o), .green_i(green_o), .blue_i(blue_o), .alpha_i(alpha_o),
    .last_of_run_i(last_of_run_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mismatch_cnt_o(mismatch_cnt), .pending_cnt_o(pending_cnt), .result_cnt_o(result_cnt)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random backpressure, plus one long hold on request
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stall_req) begin
      stall_req  = 1'b0;
      stall_left = 300;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int dim_of(input logic [SIZE_W-1:0] r);
    if (r == '0) return 1;
    if (r > 9'd256) return 256;
    return int'(r);
  endfunction

  // Hold until every expected result has left, then let the pipeline empty
  task automatic wait_drained();
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_sizes(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                           input logic [SIZE_W-1:0] sz);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_SIZE_X;
    cfg_data_i <= sx;
    @(negedge clk_i);
    cfg_idx_i <= CFG_SIZE_Y;
    cfg_data_i <= sy;
    @(negedge clk_i);
    cfg_idx_i <= CFG_SIZE_Z;
    cfg_data_i <= sz;
    @(negedge clk_i);
    cfg_idx_i <= CFG_IDX_SPARE;
    cfg_data_i <= 9'(~sx);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one voxel request; called and returns at a falling edge
  task automatic push_voxel(input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    voxel_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent_cnt++;
    if (sent_cnt < 500) begin
      send_idle_pct = 31;
      recv_idle_pct = 57;
    end else if (sent_cnt < 1000) begin
      send_idle_pct = 57;
      recv_idle_pct = 31;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if (sent_cnt == 700) stall_req = 1'b1;
    if (sent_cnt == 1200) begin
      in_valid_i <= 1'b0;
      while (pending_cnt != 0) @(negedge clk_i);
    end
  endtask

  // One full volume: configure while idle, then stream every voxel
  task automatic run_volume(input logic [SIZE_W-1:0] rx, input logic [SIZE_W-1:0] ry,
                            input logic [SIZE_W-1:0] rz, input bit directed_fill);
    int         n, i, mode;
    logic [7:0] base, v;
    n    = dim_of(rx) * dim_of(ry) * dim_of(rz);
    mode = $urandom_range(2);
    base = 8'($urandom);
    in_valid_i <= 1'b0;
    wait_drained();
    set_sizes(rx, ry, rz);
    for (i = 0; i < n; i++) begin
      if (directed_fill) v = (i == 0) ? 8'd0 : (i == n - 1) ? 8'd255 : 8'd128;
      else if (mode == 0) v = 8'($urandom);
      else if (mode == 1) v = base + 8'($urandom_range(6)) - 8'd3;
      else v = 8'(i * 7) ^ 8'($urandom_range(3));
      push_voxel(v);
    end
    volume_cnt++;
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    voxel_value_i = '0;
    out_ready_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_SIZE_X;
    cfg_data_i    = '0;
    send_idle_pct = 31;
    recv_idle_pct = 57;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: interior zero gradient with extreme corners, then a single voxel
    run_volume(9'd3, 9'd3, 9'd3, 1'b1);
    run_volume(9'd0, 9'd0, 9'd0, 1'b0);

    // Extreme sizes, including saturation of oversized writes
    run_volume(9'd511, 9'd1, 9'd1, 1'b0);
    run_volume(9'd1, 9'd300, 9'd1, 1'b0);
    run_volume(9'd1, 9'd1, 9'd256, 1'b0);

    // Random small volumes
    while (sent_cnt < TARGET_ITEMS)
      run_volume(9'($urandom_range(1, 7)), 9'($urandom_range(1, 7)),
                 9'($urandom_range(1, 6)), 1'b0);

    in_valid_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Streamed %0d voxels in %0d volumes and checked %0d RGBA results,",
             sent_cnt, volume_cnt, result_cnt);
    $display("covering edge sizes 1 and 256, a long output hold and a full drain.");
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
